// ===== design/rta_pkg.sv =====
// rta_pkg: shared widths, register indexes, reset values and the
// command/status structs between the averager controller and datapath
// no dependencies
package rta_pkg;

   localparam int SAMPLE_COUNT_DEF = 16;

   localparam int ADC_W = 12;
   localparam int POS_W = 10;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_THRESH = 1'd0;
   localparam csr_idx_type CSR_WINDOW = 1'd1;

   localparam logic [POS_W-1:0] THRESH_RESET = 10'd64;
   localparam logic [POS_W-1:0] WINDOW_RESET = 10'd5;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic scan;
      logic prep;
      logic div;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic avg_tick;
      logic scan_last;
      logic div_last;
   } status_type;

endpackage

// ===== design/rta_if.sv =====
// rta_if: valid/ready channel interfaces for request, response and csr writes
// depends on rta_pkg
interface rta_req_if;
   logic                      valid;
   logic                      ready;
   logic [rta_pkg::ADC_W-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface rta_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      drive_axis;
   logic                      start_conversion;
   logic [rta_pkg::POS_W-1:0] position_x;
   logic [rta_pkg::POS_W-1:0] position_y;
   logic                      report_done;

   modport source (output valid, output drive_axis, output start_conversion,
                   output position_x, output position_y, output report_done,
                   input ready);
   modport sink   (input valid, input drive_axis, input start_conversion,
                   input position_x, input position_y, input report_done,
                   output ready);
endinterface

interface rta_csr_if;
   logic                           valid;
   logic                           ready;
   logic [rta_pkg::CSR_IDX_W-1:0]  index;
   logic [rta_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/rta_ram.sv =====
// rta_ram: generic single-write, single-read ram with registered read data
// no dependencies
module rta_ram #(
   parameter int WIDTH  = 10,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/rta_ctrl.sv =====
// rta_ctrl: sequencing state machine of the touch averager
// depends on rta_pkg
module rta_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rta_pkg::cmd_type    cmd,
   input  rta_pkg::status_type status
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_PREP   = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               if (status.avg_tick) begin
                  state_in = ST_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/rta_datapath.sv =====
// rta_datapath: phase counter, sample rams, accumulators, serial divider
// and position registers of the touch averager; depends on rta_pkg, rta_ram
module rta_datapath #(
   parameter int SAMPLE_COUNT = rta_pkg::SAMPLE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rta_pkg::cmd_type              cmd,
   output rta_pkg::status_type           status,
   input  logic [rta_pkg::ADC_W-1:0]     adc_sample,
   input  logic                          csr_we,
   input  rta_pkg::csr_idx_type          csr_index,
   input  logic [rta_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                          drive_axis,
   output logic                          start_conversion,
   output logic [rta_pkg::POS_W-1:0]     position_x,
   output logic [rta_pkg::POS_W-1:0]     position_y,
   output logic                          report_done
);

   localparam int POS_W   = rta_pkg::POS_W;
   localparam int ADC_W   = rta_pkg::ADC_W;
   localparam int ADDR_W  = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
   localparam int SLOT_W  = $clog2(SAMPLE_COUNT + 2);
   localparam int CNT_W   = $clog2(SAMPLE_COUNT + 1);
   localparam int SUM_W   = $clog2(SAMPLE_COUNT * (2**POS_W - 1) + 1);
   localparam int STEP_W  = $clog2(POS_W);

   localparam logic [SLOT_W-1:0] SLOT_SWITCH = SLOT_W'(SAMPLE_COUNT + 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST   = ADDR_W'(SAMPLE_COUNT - 1);

   // phase and output registers
   logic              axis_ff, axis_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              start_ff, start_in;
   logic              done_ff, done_in;
   logic [POS_W-1:0]  rep_x_ff, rep_x_in, rep_y_ff, rep_y_in;
   logic [POS_W-1:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [POS_W-1:0]  thresh_ff, thresh_in, window_ff, window_in;

   // scan and divide registers
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              rd_vld_ff;
   logic [SUM_W-1:0]  sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [SUM_W-1:0]  dvs_ff, dvs_in;
   logic [POS_W-1:0]  quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic              is_switch;
   logic              ram_we;
   logic [ADDR_W-1:0] waddr;
   logic [POS_W-1:0]  scaled;
   logic [POS_W-1:0]  rd_x, rd_y;
   logic              pressed;
   logic              ge_x, ge_y;
   logic [POS_W-1:0]  diff_x, diff_y;
   logic              stable;

   assign is_switch = (slot_ff == SLOT_SWITCH);
   assign scaled    = adc_sample[ADC_W-1:ADC_W-POS_W];
   assign ram_we    = cmd.accept && !is_switch && (slot_ff != '0);
   assign waddr     = ADDR_W'(slot_ff - SLOT_W'(1));

   rta_ram #(.WIDTH(POS_W), .DEPTH(SAMPLE_COUNT), .ADDR_W(ADDR_W)) u_x_ram (
      .clock (clock),
      .we    (ram_we && !axis_ff),
      .waddr (waddr),
      .wdata (scaled),
      .raddr (addr_ff),
      .rdata (rd_x)
   );

   rta_ram #(.WIDTH(POS_W), .DEPTH(SAMPLE_COUNT), .ADDR_W(ADDR_W)) u_y_ram (
      .clock (clock),
      .we    (ram_we && axis_ff),
      .waddr (waddr),
      .wdata (scaled),
      .raddr (addr_ff),
      .rdata (rd_y)
   );

   assign pressed = (rd_x > thresh_ff) && (rd_y > thresh_ff);
   assign ge_x    = (rem_x_ff >= dvs_ff);
   assign ge_y    = (rem_y_ff >= dvs_ff);
   assign diff_x  = (prev_x_ff > quo_x_ff) ? prev_x_ff - quo_x_ff : quo_x_ff - prev_x_ff;
   assign diff_y  = (prev_y_ff > quo_y_ff) ? prev_y_ff - quo_y_ff : quo_y_ff - prev_y_ff;
   assign stable  = (diff_x < window_ff) && (diff_y < window_ff);

   always_comb begin
      axis_in   = axis_ff;
      slot_in   = slot_ff;
      start_in  = start_ff;
      done_in   = done_ff;
      rep_x_in  = rep_x_ff;
      rep_y_in  = rep_y_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      thresh_in = thresh_ff;
      window_in = window_ff;
      addr_in   = addr_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      count_in  = count_ff;
      rem_x_in  = rem_x_ff;
      rem_y_in  = rem_y_ff;
      dvs_in    = dvs_ff;
      quo_x_in  = quo_x_ff;
      quo_y_in  = quo_y_ff;
      step_in   = step_ff;

      if (csr_we) begin
         unique case (csr_index)
            rta_pkg::CSR_THRESH: thresh_in = csr_data;
            rta_pkg::CSR_WINDOW: window_in = csr_data;
         endcase
      end

      if (cmd.accept) begin
         done_in  = 1'b0;
         addr_in  = '0;
         sum_x_in = '0;
         sum_y_in = '0;
         count_in = '0;
         if (is_switch) begin
            axis_in  = !axis_ff;
            slot_in  = '0;
            start_in = 1'b0;
         end else begin
            slot_in  = slot_ff + SLOT_W'(1);
            start_in = 1'b1;
         end
      end

      if (cmd.scan) begin
         addr_in = addr_ff + ADDR_W'(1);
      end

      // read data arrives in the cycle after its address
      if (rd_vld_ff && pressed) begin
         sum_x_in = sum_x_ff + SUM_W'(rd_x);
         sum_y_in = sum_y_ff + SUM_W'(rd_y);
         count_in = count_ff + CNT_W'(1);
      end

      if (cmd.prep) begin
         rem_x_in = sum_x_ff;
         rem_y_in = sum_y_ff;
         dvs_in   = SUM_W'(count_ff) << (POS_W - 1);
         quo_x_in = '0;
         quo_y_in = '0;
         step_in  = STEP_W'(POS_W - 1);
      end

      // restoring division, one quotient bit per cycle on both axes
      if (cmd.div) begin
         rem_x_in = ge_x ? rem_x_ff - dvs_ff : rem_x_ff;
         rem_y_in = ge_y ? rem_y_ff - dvs_ff : rem_y_ff;
         quo_x_in = {quo_x_ff[POS_W-2:0], ge_x};
         quo_y_in = {quo_y_ff[POS_W-2:0], ge_y};
         dvs_in   = dvs_ff >> 1;
         step_in  = step_ff - STEP_W'(1);
      end

      if (cmd.finish) begin
         done_in = 1'b1;
         if (count_ff == '0) begin
            rep_x_in = '0;
            rep_y_in = '0;
         end else begin
            if (stable) begin
               rep_x_in = quo_x_ff;
               rep_y_in = quo_y_ff;
            end
            prev_x_in = quo_x_ff;
            prev_y_in = quo_y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff   <= 1'b0;
         slot_ff   <= '0;
         rep_x_ff  <= '0;
         rep_y_ff  <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         thresh_ff <= rta_pkg::THRESH_RESET;
         window_ff <= rta_pkg::WINDOW_RESET;
         rd_vld_ff <= 1'b0;
      end else begin
         axis_ff   <= axis_in;
         slot_ff   <= slot_in;
         rep_x_ff  <= rep_x_in;
         rep_y_ff  <= rep_y_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         thresh_ff <= thresh_in;
         window_ff <= window_in;
         rd_vld_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      done_ff  <= done_in;
      addr_ff  <= addr_in;
      sum_x_ff <= sum_x_in;
      sum_y_ff <= sum_y_in;
      count_ff <= count_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      dvs_ff   <= dvs_in;
      quo_x_ff <= quo_x_in;
      quo_y_ff <= quo_y_in;
      step_ff  <= step_in;
   end

   assign status.avg_tick  = is_switch && axis_ff;
   assign status.scan_last = (addr_ff == ADDR_LAST);
   assign status.div_last  = (step_ff == '0);

   assign drive_axis       = axis_ff;
   assign start_conversion = start_ff;
   assign position_x       = rep_x_ff;
   assign position_y       = rep_y_ff;
   assign report_done      = done_ff;

endmodule

// ===== design/resistive_touch_averager_unit.sv =====
// resistive_touch_averager_unit: top level of the resistive touch averager
// depends on rta_pkg, rta_if, rta_ctrl, rta_datapath (and rta_ram below it)
//
// usage
//   req_chan carries one converter reading per timer tick; rsp_chan returns
//   exactly one response per request: the axis to drive next, whether a
//   conversion is started, the reported position and the averaging flag.
//   csr_chan writes press_threshold (index 0) and stability_window (index 1);
//   it is always ready and should only be written while the block is idle.
// response path
//   an ordinary tick is answered in the next cycle, and the next request
//   can be taken once the receiver takes that response. the tick that
//   closes the Y phase scans both sample rams one entry a cycle, then
//   goes through drain, divider setup, the bit-serial divider and a
//   finish state before its response is registered. a full X plus
//   Y round is 2 * (SAMPLE_COUNT + 2) ticks.
// reset
//   synchronous, active high: X axis, discard slot, positions and previous
//   averages zero, registers to 64 and 5. sample rams are not cleared; a
//   full X and Y phase always precede the first average.
// back-pressure
//   the response sits in its output register until taken; a new request is
//   accepted in the same cycle that the pending response leaves.
module resistive_touch_averager_unit #(
   parameter int SAMPLE_COUNT = rta_pkg::SAMPLE_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rta_req_if.sink    req_chan,
   rta_rsp_if.source  rsp_chan,
   rta_csr_if.sink    csr_chan
);

   rta_pkg::cmd_type    cmd;
   rta_pkg::status_type status;

   // csr writes are always taken
   assign csr_chan.ready = 1'b1;

   // sequencing: accepts a request, walks scan and divide, releases response
   rta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // storage and arithmetic; position registers double as the response payload
   rta_datapath #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .adc_sample       (req_chan.adc_sample),
      .csr_we           (csr_chan.valid),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .drive_axis       (rsp_chan.drive_axis),
      .start_conversion (rsp_chan.start_conversion),
      .position_x       (rsp_chan.position_x),
      .position_y       (rsp_chan.position_y),
      .report_done      (rsp_chan.report_done)
   );

   // an ordinary request is answered in the very next cycle
   a_fast_reply: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !status.avg_tick) |=> rsp_chan.valid)
      else $error("ordinary request not answered in one cycle");

   // averaging ends on the switch tick into the X phase
   a_done_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.report_done) |->
         (!rsp_chan.start_conversion && !rsp_chan.drive_axis))
      else $error("averaging response not on the switch tick into X");

   // the output register must be free when a new average lands
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_chan.valid)
      else $error("average finished over a pending response");

   // both coordinates are zero together or both valid averages
   a_pos_pair: assert property (@(posedge clock) disable iff (reset)
      ((rsp_chan.position_x == '0) == (rsp_chan.position_y == '0)))
      else $error("one coordinate zero without the other");

endmodule

// ===== verif/resistive_touch_averager_unit_test.sv =====
// resistive_touch_averager_unit_test: self-checking bench for the touch averager,
// with a tick-by-tick predictor, random touch rounds and back-pressure on both sides
// depends on rta_pkg, rta_if and resistive_touch_averager_unit
module resistive_touch_averager_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_COUNT = rta_pkg::SAMPLE_COUNT_DEF;
   localparam int POS_W        = rta_pkg::POS_W;
   localparam int ADC_W        = rta_pkg::ADC_W;
   localparam int CSR_DATA_W   = rta_pkg::CSR_DATA_W;
   // slowest response: ram scan plus the serial divider
   localparam int AVERAGE_LATENCY = SAMPLE_COUNT + 13;

   // expected response for one request
   typedef struct {
      logic             drive_axis;
      logic             start_conversion;
      logic [POS_W-1:0] position_x;
      logic [POS_W-1:0] position_y;
      logic             report_done;
   } tick_result_type;

   // how the random generator shapes one X plus Y round
   typedef enum int {
      ROUND_STEADY,  // same touch, small drift
      ROUND_JUMP,    // touch moves somewhere new
      ROUND_LIFTED,  // nothing pressed
      ROUND_NOISE    // raw random readings
   } round_style_type;

   logic clock = 1'b0;
   logic reset;

   rta_req_if req_chan ();
   rta_rsp_if rsp_chan ();
   rta_csr_if csr_chan ();

   resistive_touch_averager_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #1 clock = ~clock;

   // predictor state, mirrors the block from reset
   logic             touch_axis = 1'b0;
   int               touch_slot = 0;
   logic [POS_W-1:0] x_store [SAMPLE_COUNT];
   logic [POS_W-1:0] y_store [SAMPLE_COUNT];
   logic [POS_W-1:0] prev_avg_x = '0;
   logic [POS_W-1:0] prev_avg_y = '0;
   logic [POS_W-1:0] shown_x = '0;
   logic [POS_W-1:0] shown_y = '0;
   logic [POS_W-1:0] press_level = rta_pkg::THRESH_RESET;
   logic [POS_W-1:0] window_level = rta_pkg::WINDOW_RESET;

   tick_result_type tick_expected [$];
   int              mismatches = 0;

   // idling controls for the sender (req_idle) and the receiver (rsp_idle, hold_request)
   bit req_idle = 1'b1;
   bit rsp_idle = 1'b1;
   bit hold_request = 1'b0;

   // random round shaping
   round_style_type round_style = ROUND_NOISE;
   int              base_x = 512;
   int              base_y = 512;

   // average the pressed pairs at the close of the Y phase
   function automatic void average_pairs();
      int               sum_x;
      int               sum_y;
      int               pairs;
      int               dx;
      int               dy;
      logic [POS_W-1:0] avg_x;
      logic [POS_W-1:0] avg_y;
      sum_x = 0;
      sum_y = 0;
      pairs = 0;
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         if (x_store[i] > press_level && y_store[i] > press_level) begin
            sum_x += x_store[i];
            sum_y += y_store[i];
            pairs++;
         end
      end
      // no pressed pair: position cleared, previous averages kept
      if (pairs == 0) begin
         shown_x = '0;
         shown_y = '0;
         return;
      end
      avg_x = POS_W'(sum_x / pairs);
      avg_y = POS_W'(sum_y / pairs);
      dx = (prev_avg_x > avg_x) ? prev_avg_x - avg_x : avg_x - prev_avg_x;
      dy = (prev_avg_y > avg_y) ? prev_avg_y - avg_y : avg_y - prev_avg_y;
      // a zero window never lets a new position through
      if (dx < window_level && dy < window_level) begin
         shown_x = avg_x;
         shown_y = avg_y;
      end
      prev_avg_x = avg_x;
      prev_avg_y = avg_y;
   endfunction

   // advance the predictor by one tick and return the response it owes
   function automatic tick_result_type predict_tick(logic [ADC_W-1:0] sample);
      tick_result_type  r;
      logic [POS_W-1:0] scaled;
      scaled = sample[ADC_W-1:2];
      r.start_conversion = 1'b0;
      r.report_done = 1'b0;
      if (touch_slot > SAMPLE_COUNT) begin
         // switch tick: reading ignored, no conversion, axis flips
         if (touch_axis) begin
            average_pairs();
            r.report_done = 1'b1;
         end
         touch_axis = ~touch_axis;
         touch_slot = 0;
      end else begin
         // slot 0 is the discard tick, its reading is dropped
         if (touch_slot >= 1) begin
            if (touch_axis) y_store[touch_slot-1] = scaled;
            else x_store[touch_slot-1] = scaled;
         end
         touch_slot++;
         r.start_conversion = 1'b1;
      end
      r.drive_axis = touch_axis;
      r.position_x = shown_x;
      r.position_y = shown_y;
      return r;
   endfunction

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", field, want, got);
         mismatches++;
      end
   endfunction

   function automatic int clamp_pos(int v);
      if (v < 0) return 0;
      if (v > 1023) return 1023;
      return v;
   endfunction

   // pick the next random reading, shaped by the round it falls in
   function automatic logic [ADC_W-1:0] pick_reading();
      int v;
      // a fresh round starts on the X discard tick
      if (!touch_axis && touch_slot == 0) begin
         case ($urandom_range(0, 19))
            0, 1, 2:    round_style = ROUND_JUMP;
            3, 4, 5:    round_style = ROUND_LIFTED;
            6, 7:       round_style = ROUND_NOISE;
            default:    round_style = ROUND_STEADY;
         endcase
         if (round_style == ROUND_JUMP) begin
            base_x = $urandom_range(0, 1023);
            base_y = $urandom_range(0, 1023);
         end else if (round_style == ROUND_STEADY) begin
            base_x = clamp_pos(base_x + int'($urandom_range(0, 2)) - 1);
            base_y = clamp_pos(base_y + int'($urandom_range(0, 2)) - 1);
         end
      end
      if (round_style == ROUND_NOISE) return ADC_W'($urandom_range(0, 4095));
      // lifted rounds, and the odd released pair inside a touch
      if (round_style == ROUND_LIFTED || $urandom_range(0, 7) == 0)
         return ADC_W'($urandom_range(0, 255));
      v = (touch_axis ? base_y : base_x) * 4 + int'($urandom_range(0, 7)) - 2;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return ADC_W'(v);
   endfunction

   // offer one request, predict its response once it is taken
   task automatic send_reading(logic [ADC_W-1:0] sample);
      int gap;
      gap = req_idle ? $urandom_range(0, 9) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.adc_sample <= sample;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      tick_expected.push_back(predict_tick(sample));
   endtask

   task automatic send_random(int count);
      repeat (count) send_reading(pick_reading());
   endtask

   // stop offering, let every response come back, then allow the block to settle
   task automatic wait_for_drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (tick_expected.size() != 0) @(posedge clock);
      repeat (AVERAGE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_register(rta_pkg::csr_idx_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      if (idx == rta_pkg::CSR_THRESH) press_level = value;
      else if (idx == rta_pkg::CSR_WINDOW) window_level = value;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // both registers, one after the other, only ever with the block idle
   task automatic set_registers(logic [CSR_DATA_W-1:0] threshold,
                                logic [CSR_DATA_W-1:0] window);
      wait_for_drain();
      write_register(rta_pkg::CSR_THRESH, threshold);
      write_register(rta_pkg::CSR_WINDOW, window);
   endtask

   // field extremes, discard and switch ticks, threshold edge values
   task automatic test_directed_readings();
      logic [ADC_W-1:0] readings [25];
      readings = '{12'hFFF, 12'h000, 12'hFFF, 12'h001, 12'h002, 12'h003, 12'h100,
                   12'h103, 12'h104, 12'hAAA, 12'h555, 12'hFFC, 12'hFFE, 12'h7FF,
                   12'h800, 12'h3FF, 12'h400, 12'hFFF, 12'h000, 12'hFFF, 12'h000,
                   12'h123, 12'hEDC, 12'h000, 12'hFFF};
      foreach (readings[i]) send_reading(readings[i]);
   endtask

   // reset values of the registers, random rounds
   task automatic test_default_registers();
      send_random(220);
   endtask

   // threshold 0 so every nonzero pair counts, window 1023, no idling on either side
   task automatic test_open_threshold();
      set_registers(10'd0, 10'd1023);
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      send_random(140);
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   // nothing can exceed the top threshold, narrowest usable window
   task automatic test_closed_threshold();
      set_registers(10'd1023, 10'd1);
      send_random(110);
   endtask

   // zero window: no new position shows, but the averages still move
   task automatic test_zero_window();
      set_registers(CSR_DATA_W'($urandom_range(0, 300)), 10'd0);
      send_random(110);
   endtask

   // long receiver hold-off while requests keep coming, then a full pause
   task automatic test_back_pressure();
      set_registers(10'd200, 10'd20);
      send_random(100);
      hold_request = 1'b1;
      send_random(30);
      wait_for_drain();
      send_random(120);
   endtask

   // receiver: random stalls per response, compares against the oldest prediction
   initial begin : response_checker
      int              stall;
      tick_result_type want;
      rsp_chan.ready = 1'b0;
      forever begin
         stall = rsp_idle ? $urandom_range(0, 9) : 0;
         if (hold_request) begin
            // long stretch so the output register fills and the input stalls
            stall = 80;
            hold_request = 1'b0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         if (tick_expected.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = tick_expected.pop_front();
            check_field("drive_axis", want.drive_axis, rsp_chan.drive_axis);
            check_field("start_conversion", want.start_conversion,
                        rsp_chan.start_conversion);
            check_field("position_x", want.position_x, rsp_chan.position_x);
            check_field("position_y", want.position_y, rsp_chan.position_y);
            check_field("report_done", want.report_done, rsp_chan.report_done);
         end
      end
   end

   // main sequence
   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.adc_sample = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = rta_pkg::CSR_THRESH;
      csr_chan.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_readings();
      test_default_registers();
      test_open_threshold();
      test_closed_threshold();
      test_zero_window();
      test_back_pressure();

      wait_for_drain();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #1ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/rta_pkg.sv
design/rta_if.sv
design/rta_ram.sv
design/rta_ctrl.sv
design/rta_datapath.sv
design/resistive_touch_averager_unit.sv
verif/resistive_touch_averager_unit_test.sv
